// File: rtl/alarm_snooze_repeat_scheduler_top_macros.svh
// assertion macros for the alarm snooze repeat scheduler
// no dependencies; included by the top level only
`ifndef ALARM_SNOOZE_REPEAT_SCHEDULER_TOP_MACROS_SVH
`define ALARM_SNOOZE_REPEAT_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asrs assertion failed");

// next-cycle implication, checked outside reset
`define ASRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asrs assertion failed");

`endif

// File: rtl/asrs_pkg.sv
// shared types, constants and level decode functions for the alarm scheduler
// no dependencies
`timescale 1ns / 1ps

package asrs_pkg;

   // event modes
   localparam logic [1:0] MODE_CHECK  = 2'd0;
   localparam logic [1:0] MODE_SNOOZE = 2'd1;
   localparam logic [1:0] MODE_RECORD = 2'd2;

   // alarm levels
   localparam logic [2:0] LVL_NORMAL    = 3'd0;
   localparam logic [2:0] LVL_LOW_ALARM = 3'd1;
   localparam logic [2:0] LVL_HIGH_ALARM = 3'd2;
   localparam logic [2:0] LVL_LOOP_ERR  = 3'd3;
   localparam logic [2:0] LVL_LOW_WARN  = 3'd4;
   localparam logic [2:0] LVL_HIGH_WARN = 3'd5;
   localparam logic [2:0] LVL_NO_DATA   = 3'd6;

   // directions
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_LOW  = 2'd1;
   localparam logic [1:0] DIR_HIGH = 2'd2;
   localparam logic [1:0] DIR_DATA = 2'd3;

   // sound codes
   localparam logic [2:0] SND_NONE       = 3'd0;
   localparam logic [2:0] SND_LOW_ALARM  = 3'd1;
   localparam logic [2:0] SND_HIGH_ALARM = 3'd2;
   localparam logic [2:0] SND_LOW_WARN   = 3'd3;
   localparam logic [2:0] SND_HIGH_WARN  = 3'd4;
   localparam logic [2:0] SND_NO_DATA    = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_SNOOZE_MIN  = 2'd0;
   localparam logic [1:0] CSR_REPEAT_MIN  = 2'd1;
   localparam logic [1:0] CSR_SNOOZE_MAX  = 2'd2;
   localparam logic [1:0] CSR_DEBOUNCE_MS = 2'd3;

   localparam int CSR_DATA_W = 20;

   // time conversion
   localparam logic [15:0] MS_PER_MIN  = 16'd60000;
   localparam logic [5:0]  SEC_PER_MIN = 6'd60;
   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT, exact for every 32-bit x
   localparam logic [28:0] RECIP_1000  = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;

   // register reset values, with the derived forms kept by the block
   localparam logic [21:0] RST_STEP_SEC  = 22'd1800;
   localparam logic [31:0] RST_REPEAT_MS = 32'd300000;
   localparam logic [19:0] RST_MAX_SEC   = 20'd14400;
   localparam logic [15:0] RST_DEBOUNCE  = 16'd1000;

   typedef struct packed {
      logic [21:0] step_sec;    // snooze step in seconds, zero minutes taken as one
      logic [31:0] repeat_ms;   // repeat interval in ms
      logic [19:0] max_sec;
      logic [15:0] debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
      logic [2:0]  level;
   } req_item_type;

   typedef struct packed {
      logic        fire;
      logic [2:0]  sound_code;
      logic [19:0] snooze_left_sec;
      logic        snooze_applied;
   } rsp_item_type;

   function automatic logic [1:0] rank_of(input logic [2:0] lv);
      logic [1:0] r;
      case (lv) inside
         LVL_LOW_ALARM, LVL_HIGH_ALARM:           r = 2'd3;
         LVL_LOOP_ERR, LVL_LOW_WARN, LVL_HIGH_WARN: r = 2'd2;
         LVL_NO_DATA:                             r = 2'd1;
         default:                                 r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] dir_of(input logic [2:0] lv);
      logic [1:0] d;
      case (lv) inside
         LVL_LOW_ALARM, LVL_LOW_WARN:   d = DIR_LOW;
         LVL_HIGH_ALARM, LVL_HIGH_WARN: d = DIR_HIGH;
         LVL_LOOP_ERR, LVL_NO_DATA:     d = DIR_DATA;
         default:                       d = DIR_NONE;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] sound_of(input logic [2:0] lv);
      logic [2:0] s;
      case (lv) inside
         LVL_LOW_ALARM:             s = SND_LOW_ALARM;
         LVL_HIGH_ALARM:            s = SND_HIGH_ALARM;
         LVL_LOW_WARN:              s = SND_LOW_WARN;
         LVL_HIGH_WARN:             s = SND_HIGH_WARN;
         LVL_LOOP_ERR, LVL_NO_DATA: s = SND_NO_DATA;
         default:                   s = SND_NONE;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/asrs_req_if.sv
// event channel: valid/ready handshake with mode, time and level
// no dependencies
`timescale 1ns / 1ps

interface asrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] now_ms;
   logic [2:0]  level;

   modport source (output valid, output mode, output now_ms, output level, input ready);
   modport sink   (input valid, input mode, input now_ms, input level, output ready);
endinterface

// File: rtl/asrs_rsp_if.sv
// result channel: valid/ready handshake with fire decision and snooze status
// no dependencies
`timescale 1ns / 1ps

interface asrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        fire;
   logic [2:0]  sound_code;
   logic [19:0] snooze_left_sec;
   logic        snooze_applied;

   modport source (output valid, output fire, output sound_code, output snooze_left_sec,
                   output snooze_applied, input ready);
   modport sink   (input valid, input fire, input sound_code, input snooze_left_sec,
                   input snooze_applied, output ready);
endinterface

// File: rtl/asrs_cfg.sv
// configuration registers, kept in the derived units the datapath uses
// depends on asrs_pkg
`timescale 1ns / 1ps

module asrs_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [asrs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output asrs_pkg::cfg_type              cfg
);

   asrs_pkg::cfg_type cfg_ff, cfg_in;
   logic [15:0] minutes;
   logic [15:0] snz_minutes;

   always_comb begin
      minutes     = csr_wdata[15:0];
      snz_minutes = (minutes == 16'd0) ? 16'd1 : minutes;
      cfg_in      = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            asrs_pkg::CSR_SNOOZE_MIN: begin
               cfg_in.step_sec = 22'(snz_minutes * 22'(asrs_pkg::SEC_PER_MIN));
            end
            asrs_pkg::CSR_REPEAT_MIN: begin
               cfg_in.repeat_ms = 32'(minutes) * 32'(asrs_pkg::MS_PER_MIN);
            end
            asrs_pkg::CSR_SNOOZE_MAX: begin
               cfg_in.max_sec = csr_wdata[19:0];
            end
            asrs_pkg::CSR_DEBOUNCE_MS: begin
               cfg_in.debounce_ms = csr_wdata[15:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_sec    <= asrs_pkg::RST_STEP_SEC;
         cfg_ff.repeat_ms   <= asrs_pkg::RST_REPEAT_MS;
         cfg_ff.max_sec     <= asrs_pkg::RST_MAX_SEC;
         cfg_ff.debounce_ms <= asrs_pkg::RST_DEBOUNCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/asrs_sec_div.sv
// millisecond to whole-second conversion by reciprocal multiply
// depends on asrs_pkg
`timescale 1ns / 1ps

module asrs_sec_div (
   input  logic [31:0] ms,
   output logic [22:0] sec
);

   logic [60:0] prod;

   assign prod = 61'(ms) * 61'(asrs_pkg::RECIP_1000);
   // quotient of a 32-bit value by 1000 needs 23 bits
   assign sec  = prod[asrs_pkg::RECIP_SHIFT +: 23];

endmodule

// File: rtl/asrs_engine.sv
// scheduler state and single-pass decision logic for one event
// depends on asrs_pkg and asrs_sec_div
`timescale 1ns / 1ps

module asrs_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  asrs_pkg::req_item_type item,
   input  asrs_pkg::cfg_type      cfg,
   output asrs_pkg::rsp_item_type result
);

   logic [31:0] start_ff, start_in;
   logic [19:0] len_ff, len_in;
   logic [2:0]  snz_lvl_ff, snz_lvl_in;
   logic [31:0] last_fire_ff, last_fire_in;
   logic        fired_once_ff, fired_once_in;

   logic [31:0] elapsed;
   logic [22:0] gone_sec;
   logic        active;
   logic [19:0] left;
   logic        suppress;
   logic        repeat_due;
   logic        fire;
   logic        same_lvl;
   logic        debounced;
   logic [22:0] dur_raw;
   logic [19:0] dur;
   logic        applied;

   asrs_sec_div u_sec_div (
      .ms  (elapsed),
      .sec (gone_sec)
   );

   always_comb begin
      elapsed = item.now_ms - start_ff;
      active  = (len_ff != 20'd0) && (gone_sec < 23'(len_ff));
      left    = active ? (len_ff - gone_sec[19:0]) : 20'd0;

      // check: quiet while a snooze covers this direction at equal or higher rank
      suppress = active
                 && (asrs_pkg::dir_of(item.level) == asrs_pkg::dir_of(snz_lvl_ff))
                 && (asrs_pkg::rank_of(item.level) <= asrs_pkg::rank_of(snz_lvl_ff));
      repeat_due = (item.now_ms - last_fire_ff) > cfg.repeat_ms;
      fire = (item.mode == asrs_pkg::MODE_CHECK) && (item.level != asrs_pkg::LVL_NORMAL)
             && !suppress && (!fired_once_ff || repeat_due);

      // snooze: extend a live snooze at the same level, ignore presses in the window
      same_lvl  = active && (item.level == snz_lvl_ff);
      debounced = same_lvl && (elapsed < 32'(cfg.debounce_ms));
      dur_raw   = same_lvl ? (23'(left) + 23'(cfg.step_sec)) : 23'(cfg.step_sec);
      dur       = (dur_raw > 23'(cfg.max_sec)) ? cfg.max_sec : dur_raw[19:0];
      applied   = (item.mode == asrs_pkg::MODE_SNOOZE) && !debounced;

      start_in      = start_ff;
      len_in        = len_ff;
      snz_lvl_in    = snz_lvl_ff;
      last_fire_in  = last_fire_ff;
      fired_once_in = fired_once_ff;
      if (advance) begin
         case (item.mode)
            asrs_pkg::MODE_SNOOZE: begin
               if (applied) begin
                  start_in   = item.now_ms;
                  len_in     = dur;
                  snz_lvl_in = item.level;
               end
            end
            asrs_pkg::MODE_RECORD: begin
               last_fire_in  = item.now_ms;
               fired_once_in = 1'b1;
            end
            default: begin
               fired_once_in = fired_once_ff;
            end
         endcase
      end

      result.fire            = fire;
      result.sound_code      = asrs_pkg::sound_of(item.level);
      result.snooze_left_sec = applied ? dur : left;
      result.snooze_applied  = applied;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= 32'd0;
         len_ff        <= 20'd0;
         snz_lvl_ff    <= asrs_pkg::LVL_NORMAL;
         last_fire_ff  <= 32'd0;
         fired_once_ff <= 1'b0;
      end else begin
         start_ff      <= start_in;
         len_ff        <= len_in;
         snz_lvl_ff    <= snz_lvl_in;
         last_fire_ff  <= last_fire_in;
         fired_once_ff <= fired_once_in;
      end
   end

endmodule

// File: rtl/alarm_snooze_repeat_scheduler_top.sv
// top level of the alarm snooze and repeat scheduler: channels, pipeline registers
// depends on asrs_pkg, asrs_req_if, asrs_rsp_if, asrs_cfg, asrs_engine and the macros header
`timescale 1ns / 1ps

`include "alarm_snooze_repeat_scheduler_top_macros.svh"

// Alarm snooze and repeat scheduler. Every event transfer (check, snooze or record, with
// a millisecond time and an alarm level) produces exactly one result transfer carrying the
// fire decision, the sound code, the snooze seconds left and whether a snooze press took
// effect. The block takes one event per clock while the result side is ready; each event
// is held in the input register and then in the result register. The clock rate is set by
// the single-pass decision path, whose longest leg is the reciprocal multiply that turns the
// elapsed snooze time into whole seconds followed by the seconds-left compare; the scheduler
// state feeds back into that path every cycle so events that follow each other closely see
// each other's effect. Backpressure on the result side stalls the result register first and
// then the input register. Registers must be written through the csr port only while no
// event is in flight, which the block does not enforce; repeat and snooze step are kept
// pre-scaled to ms and seconds. There is no clearing pass after reset.

module alarm_snooze_repeat_scheduler_top (
   input  logic                            clock,
   input  logic                            reset,
   asrs_req_if.sink                        req_chan,
   asrs_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [asrs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   asrs_pkg::cfg_type cfg;

   // input register
   logic                   in_valid_ff, in_valid_in;
   asrs_pkg::req_item_type in_item_ff, in_item_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   asrs_pkg::rsp_item_type out_item_ff, out_item_in;

   asrs_pkg::rsp_item_type result;
   logic                   advance;   // event moves from input to result register
   logic                   req_xfer;

   asrs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   asrs_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // result register frees up when empty or when its transfer completes
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = req_xfer || (in_valid_ff && !advance);
      in_item_in  = in_item_ff;
      if (req_xfer) begin
         in_item_in.mode   = req_chan.mode;
         in_item_in.now_ms = req_chan.now_ms;
         in_item_in.level  = req_chan.level;
      end

      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_item_in  = advance ? result : out_item_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.fire            = out_item_ff.fire;
   assign rsp_chan.sound_code      = out_item_ff.sound_code;
   assign rsp_chan.snooze_left_sec = out_item_ff.snooze_left_sec;
   assign rsp_chan.snooze_applied  = out_item_ff.snooze_applied;

   // a result is never both a firing and an applied snooze
   `ASRS_ASSERT_NOW(a_fire_vs_applied, clock, reset, out_valid_ff, !(out_item_ff.fire && out_item_ff.snooze_applied))
   // an event leaving the input register always lands in the result register
   `ASRS_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)
   // a held event in the input register blocks new transfers
   `ASRS_ASSERT_NOW(a_hold_blocks, clock, reset, in_valid_ff && !advance, !req_chan.ready)

endmodule
